// ----- src/mlsa_warped_cascade_filter_assert.svh -----
`ifndef MLSA_WARPED_CASCADE_FILTER_ASSERT_SVH
`define MLSA_WARPED_CASCADE_FILTER_ASSERT_SVH
// Assertion helpers for the RTL.
`define MWC_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define MWC_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- src/mwc_pkg.sv -----
package mwc_pkg;
	localparam int DEF_MAX_ORDER = 40;
	localparam int DEF_MAX_PADE  = 5;
	localparam int DW = 40;
	localparam int SW = 32;
	localparam int MW = 64;

	localparam logic [1:0] OP_FILT = 2'd0;
	localparam logic [1:0] OP_CEP  = 2'd1;
	localparam logic [1:0] OP_PADE = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_PADE  = 2'd1;
	localparam logic [1:0] REG_ORDER = 2'd2;

	localparam logic signed [24:0] ALPHA_RST = 25'sd7046431;
	localparam logic signed [24:0] ALPHA_LIM = 25'sd16777215;

	// Operand request to the shared multiplier and its result.
	typedef struct packed {
		logic                 go;
		logic signed [DW+1:0] a;
		logic signed [SW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [MW-1:0] p;
	} mul_rsp_t;

	function automatic logic signed [DW-1:0] sat40(input logic signed [MW-1:0] v);
		logic signed [MW-1:0] hi;
		logic signed [MW-1:0] lo;
		hi = (MW'(1) <<< (DW - 1)) - MW'(1);
		lo = -(MW'(1) <<< (DW - 1));
		if (v > hi) return hi[DW-1:0];
		if (v < lo) return lo[DW-1:0];
		return v[DW-1:0];
	endfunction
endpackage

// ----- src/mlsa_warped_cascade_filter.sv -----
// Every product of a filter request goes through the one shared multiplier, in
// eight 4-bit steps. Throughput: one request at a time; in_ready low while busy
// or while a result waits. Reset (asynchronous, active low) sets registers to defaults
// and clears the delay memory, one entry per cycle, MAX_PADE*(MAX_ORDER+2) entries.
module mlsa_warped_cascade_filter #(
	parameter int MAX_ORDER = mwc_pkg::DEF_MAX_ORDER,
	parameter int MAX_PADE  = mwc_pkg::DEF_MAX_PADE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic signed [31:0] sample_in,
	input  logic [5:0]  coef_index,
	input  logic signed [31:0] coef_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] sample_out,
	output logic        saturated
);
	import mwc_pkg::*;
	`include "mlsa_warped_cascade_filter_assert.svh"

	localparam int DEPTH = MAX_PADE * (MAX_ORDER + 2);
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_ORDER + 3);
	localparam int CW    = $clog2(MAX_ORDER + 1);
	localparam int PW    = $clog2(MAX_PADE + 1);

	typedef enum logic [8:0] {
		ST_CLR  = 9'b000000001,
		ST_IDLE = 9'b000000010,
		ST_AA   = 9'b000000100,
		ST_SEC  = 9'b000001000,
		ST_TAP  = 9'b000010000,
		ST_SHF  = 9'b000100000,
		ST_PADE = 9'b001000000,
		ST_FIN  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	logic signed [24:0] alpha_q;
	logic [2:0] pade_q;
	logic [5:0] order_q;

	logic signed [DW-1:0] dmem [DEPTH];
	logic signed [SW-1:0] cep_q [MAX_ORDER+1];
	logic signed [SW-1:0] padec_q [MAX_PADE+1];
	logic signed [DW-1:0] sec_q [MAX_PADE+1];

	logic [AW-1:0] clr_q;
	logic [PW-1:0] sec_i_q;
	logic [KW-1:0] k_q;
	logic [2:0]    ph_q;
	logic          wait_q;
	logic signed [24:0] a_q;
	logic signed [MW-1:0] aa_q, t_q, y_q, x_q, acc_q;
	logic signed [DW-1:0] dm1_q, dk_q, dp1_q, new_q;
	logic [PW-1:0] pd;
	logic [5:0] m;
	mul_req_t req;
	mul_rsp_t rsp;
	logic signed [MW-1:0] satv;

	mwc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		pd = (pade_q == 3'd0) ? PW'(1) :
			(32'(pade_q) > MAX_PADE) ? PW'(MAX_PADE) : PW'(pade_q);
		m = (32'(order_q) > MAX_ORDER) ? 6'(MAX_ORDER) : order_q;
	end

	function automatic logic [AW-1:0] addr(input logic [PW-1:0] s, input logic [KW-1:0] k);
		return AW'(32'(s - PW'(1)) * (MAX_ORDER + 2) + 32'(k));
	endfunction

	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	// Sequencer. ph_q steps through: read operands, multiply, combine, write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			alpha_q <= ALPHA_RST;
			pade_q <= 3'd5;
			order_q <= 6'd24;
			out_valid <= 1'b0;
			req.go <= 1'b0;
			wait_q <= 1'b0;
			ph_q <= '0;
			for (int i = 0; i <= MAX_ORDER; i++) cep_q[i] <= '0;
			for (int i = 0; i <= MAX_PADE; i++) begin
				padec_q[i] <= '0;
				sec_q[i] <= '0;
			end
		end else begin
			req.go <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA: alpha_q <= cfg_data;
					REG_PADE:  pade_q <= cfg_data[2:0];
					REG_ORDER: order_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLR: begin
					dmem[clr_q] <= '0;
					clr_q <= clr_q + AW'(1);
					if (32'(clr_q) == DEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						case (opcode)
							OP_CEP: if (32'(coef_index) <= MAX_ORDER)
								cep_q[CW'(coef_index)] <= coef_value;
							OP_PADE: if (32'(coef_index) <= MAX_PADE)
								padec_q[coef_index[PW-1:0]] <= coef_value;
							OP_FILT: begin
								a_q <= (alpha_q < -ALPHA_LIM) ? -ALPHA_LIM : alpha_q;
								x_q <= MW'(sample_in);
								acc_q <= '0;
								ph_q <= '0;
								state_q <= ST_AA;
							end
							default: ;
						endcase
					end
				end
				ST_AA: begin
					if (!wait_q) begin
						req.go <= 1'b1; req.a <= (DW+2)'(a_q); req.b <= SW'(a_q);
						wait_q <= 1'b1;
					end else if (rsp.done) begin
						wait_q <= 1'b0;
						aa_q <= (MW'(1) <<< 24) - rsp.p;
						sec_i_q <= pd;
						ph_q <= '0;
						state_q <= ST_SEC;
					end
				end
				// d1 = sat(aa*u + alpha*d1)
				ST_SEC: begin
					case (ph_q)
						3'd0: begin dm1_q <= dmem[addr(sec_i_q, KW'(1))]; ph_q <= 3'd1; end
						3'd1: begin
							if (!wait_q) begin
								req.go <= 1'b1; req.a <= (DW+2)'(sec_q[sec_i_q - PW'(1)]);
								req.b <= SW'(aa_q); wait_q <= 1'b1;
							end else if (rsp.done) begin
								wait_q <= 1'b0; t_q <= rsp.p; ph_q <= 3'd2;
							end
						end
						default: begin
							if (!wait_q) begin
								req.go <= 1'b1; req.a <= (DW+2)'(dm1_q);
								req.b <= SW'(a_q); wait_q <= 1'b1;
							end else if (rsp.done) begin
								wait_q <= 1'b0;
								dmem[addr(sec_i_q, KW'(1))] <= sat40(t_q + rsp.p);
								y_q <= '0; k_q <= KW'(2); ph_q <= '0;
								// Order one only shifts; order zero has no taps and no shift.
								state_q <= (m >= 6'd2) ? ST_TAP :
									(m == 6'd1) ? ST_SHF : ST_PADE;
							end
						end
					endcase
				end
				ST_TAP: begin
					case (ph_q)
						3'd0: begin dm1_q <= dmem[addr(sec_i_q, k_q - KW'(1))]; ph_q <= 3'd1; end
						3'd1: begin dk_q <= dmem[addr(sec_i_q, k_q)]; ph_q <= 3'd2; end
						3'd2: begin dp1_q <= dmem[addr(sec_i_q, k_q + KW'(1))]; ph_q <= 3'd3; end
						3'd3: begin
							if (!wait_q) begin
								req.go <= 1'b1; req.a <= (DW+2)'(dp1_q) - (DW+2)'(dm1_q);
								req.b <= SW'(a_q); wait_q <= 1'b1;
							end else if (rsp.done) begin
								wait_q <= 1'b0; new_q <= sat40(MW'(dk_q) + rsp.p);
								ph_q <= 3'd4;
							end
						end
						default: begin
							if (!wait_q) begin
								dmem[addr(sec_i_q, k_q)] <= new_q;
								req.go <= 1'b1; req.a <= (DW+2)'(new_q);
								req.b <= cep_q[CW'(k_q)]; wait_q <= 1'b1;
							end else if (rsp.done) begin
								wait_q <= 1'b0; y_q <= y_q + rsp.p; ph_q <= '0;
								if (6'(k_q) == m) begin
									k_q <= KW'(m + 6'd1);
									state_q <= ST_SHF;
								end else k_q <= k_q + KW'(1);
							end
						end
					endcase
				end
				// shift d(k) <- d(k-1), top down
				ST_SHF: begin
					if (ph_q == 3'd0) begin
						dk_q <= dmem[addr(sec_i_q, k_q - KW'(1))]; ph_q <= 3'd1;
					end else begin
						dmem[addr(sec_i_q, k_q)] <= dk_q; ph_q <= '0;
						if (k_q <= KW'(2)) state_q <= ST_PADE;
						else k_q <= k_q - KW'(1);
					end
				end
				ST_PADE: begin
					if (!wait_q) begin
						sec_q[sec_i_q] <= sat40(y_q);
						req.go <= 1'b1; req.a <= (DW+2)'(sat40(y_q));
						req.b <= padec_q[sec_i_q]; wait_q <= 1'b1;
					end else if (rsp.done) begin
						wait_q <= 1'b0;
						x_q <= sec_i_q[0] ? x_q + rsp.p : x_q - rsp.p;
						acc_q <= acc_q + rsp.p;
						ph_q <= '0;
						if (sec_i_q == PW'(1)) state_q <= ST_FIN;
						else begin sec_i_q <= sec_i_q - PW'(1); state_q <= ST_SEC; end
					end
				end
				ST_FIN: begin
					sec_q[0] <= sat40(x_q);
					acc_q <= acc_q + MW'(sat40(x_q));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid <= 1'b1;
					sample_out <= (acc_q > satv) ? 32'h7fffffff :
						(acc_q < -satv - MW'(1)) ? 32'h80000000 : acc_q[31:0];
					saturated <= (acc_q > satv) || (acc_q < -satv - MW'(1));
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign satv = MW'(32'h7fffffff);

	`MWC_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`MWC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out))
	`MWC_ASSERT_IMP(a_no_go_idle, clk, arst_n, state_q == ST_IDLE, !wait_q)
endmodule

// ----- src/mwc_mul.sv -----
// Sequential multiplier: round-half-up (a*b)/2^24, four bits of b per cycle.
module mwc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mwc_pkg::mul_req_t req,
	output mwc_pkg::mul_rsp_t rsp
);
	import mwc_pkg::*;

	localparam int STEPS = SW / 4;
	// Wide enough for the full product of a 42-bit and a 32-bit operand.
	localparam int XW = MW + 16;

	logic signed [XW-1:0] acc_q;
	logic signed [XW-1:0] a_q;
	logic        [SW-1:0] b_q;
	logic        [3:0]    cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [XW-1:0] part;
	logic signed [XW-1:0] full;

	always_comb begin
		part = a_q * $signed({1'b0, b_q[3:0]});
		if (cnt_q == 4'(STEPS - 1))
			part = -(a_q * $signed({1'b0, b_q[3]})) * 8 + a_q * $signed({2'b0, b_q[2:0]});
	end

	assign full = acc_q + (part <<< (4 * cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= XW'(1) <<< 23;
				a_q    <= XW'(req.a);
				b_q    <= req.b;
			end else if (busy_q) begin
				acc_q <= full;
				b_q   <= b_q >> 4;
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = MW'(acc_q >>> 24);
endmodule

// ----- verif/tb_mlsa_warped_cascade_filter.sv -----
`timescale 1ns / 1ps

module tb_mlsa_warped_cascade_filter;
	import mwc_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] smp;
		logic [5:0]         idx;
		logic signed [31:0] val;
	} filt_req_t;

	typedef struct {
		logic signed [31:0] smp;
		logic               clip;
	} filt_out_t;

	localparam longint Q_ONE = 64'sd1 <<< 24;
	localparam longint ALPHA_MAX = (64'sd1 <<< 24) - 1;
	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [24:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic signed [31:0] sample_in;
	logic [5:0]  coef_index;
	logic signed [31:0] coef_value;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] sample_out;
	logic        saturated;

	mlsa_warped_cascade_filter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .sample_in(sample_in),
		.coef_index(coef_index), .coef_value(coef_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_out(sample_out), .saturated(saturated)
	);

	// Shadow state of the filter, held at full precision in 64-bit words.
	longint dly_line [5][42];
	longint sec_out [6];
	longint cep_tab [41];
	longint pade_tab [6];
	longint cfg_alpha;
	int     cfg_pade;
	int     cfg_order;

	filt_req_t pending_reqs[$];
	filt_out_t expected_outs[$];

	int  send_idle_pct;
	int  recv_stall_pct;
	logic in_took;
	int  errors;
	int  mismatches;
	int  cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Q24 product, rounded half up; 128-bit keeps every product exact.
	function automatic longint mul_q24(longint a, longint b);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = pa * pb + (128'sd1 <<< 23);
		return longint'(p >>> 24);
	endfunction

	function automatic longint clip_to(longint v, int bits);
		longint lim;
		lim = 64'sd1 <<< (bits - 1);
		if (v > lim - 1)
			return lim - 1;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint warp_section(int s, longint u, longint a, longint aa, int m);
		longint y;
		y = 0;
		dly_line[s][1] = clip_to(mul_q24(u, aa) + mul_q24(dly_line[s][1], a), 40);
		for (int k = 2; k <= m; k++) begin
			dly_line[s][k] = clip_to(dly_line[s][k]
				+ mul_q24(dly_line[s][k+1] - dly_line[s][k-1], a), 40);
			y += mul_q24(dly_line[s][k], cep_tab[k]);
		end
		// Shift the warped delay chain by one tap.
		for (int k = m + 1; k >= 2; k--)
			dly_line[s][k] = dly_line[s][k-1];
		return clip_to(y, 40);
	endfunction

	function automatic filt_out_t cascade_sample(longint smp);
		filt_out_t r;
		longint a, aa, x, acc, v, lim;
		int pd, m;
		a = cfg_alpha;
		if (a < -ALPHA_MAX) a = -ALPHA_MAX;
		if (a > ALPHA_MAX) a = ALPHA_MAX;
		pd = (cfg_pade < 1) ? 1 : ((cfg_pade > 5) ? 5 : cfg_pade);
		m = (cfg_order > 40) ? 40 : cfg_order;
		aa = Q_ONE - mul_q24(a, a);
		x = smp;
		acc = 0;
		for (int i = pd; i >= 1; i--) begin
			sec_out[i] = warp_section(i - 1, sec_out[i-1], a, aa, m);
			v = mul_q24(sec_out[i], pade_tab[i]);
			// Odd sections add to the feedback, even sections subtract.
			if (i % 2 == 1)
				x += v;
			else
				x -= v;
			acc += v;
		end
		x = clip_to(x, 40);
		sec_out[0] = x;
		acc += x;
		lim = 64'sd1 <<< 31;
		r.clip = (acc > lim - 1) || (acc < -lim);
		r.smp = 32'(clip_to(acc, 32));
		return r;
	endfunction

	// Cycles to let pass before a register write; writes give no result.
	function automatic int drain_cycles();
		int pd, m;
		pd = (cfg_pade < 1) ? 1 : ((cfg_pade > 5) ? 5 : cfg_pade);
		m = (cfg_order > 40) ? 40 : cfg_order;
		return 10 * (3 * m + 3) * pd + 60;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return 32'($urandom);
			1: return $signed(32'($urandom)) >>> 4;
			2: return $signed(32'($urandom)) >>> 8;
			3: return $signed(32'($urandom)) >>> 14;
			default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	function automatic filt_req_t make_req(logic [1:0] op, logic signed [31:0] smp,
			logic [5:0] idx, logic signed [31:0] val);
		filt_req_t r;
		r.op = op;
		r.smp = smp;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	// Mostly well-formed traffic: coefficient loads and filtered samples,
	// with a little noise from out-of-range indexes and the unused opcode.
	task automatic queue_random(int n);
		int cnt, pick;
		filt_req_t r;
		cnt = 0;
		while (cnt < n) begin
			pick = $urandom_range(0, 99);
			r = make_req(2'(OP_FILT), rand_word(), 6'($urandom), rand_word());
			if (pick < 50) begin
				r.op = OP_FILT;
			end else if (pick < 75) begin
				r.op = OP_CEP;
				if ($urandom_range(0, 9) != 0)
					r.idx = $urandom_range(0, 40);
			end else if (pick < 95) begin
				r.op = OP_PADE;
				if ($urandom_range(0, 9) != 0)
					r.idx = $urandom_range(0, 5);
			end else begin
				r.op = OP_RSVD;
			end
			cnt++;
			pending_reqs.push_back(r);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [24:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ALPHA: cfg_alpha = longint'($signed(data));
			REG_PADE:  cfg_pade = int'(data[2:0]);
			default:   cfg_order = int'(data[5:0]);
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every request has gone in and every result has come back.
	task automatic drain();
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_outs.size() == 0);
		repeat (drain_cycles()) @(posedge clk);
	endtask

	task automatic run_phase(logic [24:0] alpha, logic [2:0] pd, logic [5:0] m,
			int n, int mode);
		drain();
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_PADE, 25'(pd));
		write_reg(REG_ORDER, 25'(m));
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 15; recv_stall_pct = 15; end
		endcase
		queue_random(n);
	endtask

	// Driver: advance to the next request once the current one is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					filt_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					opcode <= r.op;
					sample_in <= r.smp;
					coef_index <= r.idx;
					coef_value <= r.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on each accepted request, check each accepted result.
	always @(posedge clk) begin
		filt_out_t e;
		in_took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			case (opcode)
				OP_FILT: expected_outs.push_back(cascade_sample(longint'(sample_in)));
				OP_CEP:  if (coef_index <= 40) cep_tab[coef_index] = longint'(coef_value);
				OP_PADE: if (coef_index <= 5) pade_tab[coef_index] = longint'(coef_value);
				default: ;
			endcase
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_outs.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected result: sample_out=%h saturated=%b",
						sample_out, saturated);
				mismatches++;
			end else begin
				e = expected_outs.pop_front();
				if (sample_out !== e.smp || saturated !== e.clip) begin
					errors++;
					if (mismatches < 10)
						$display("mismatch: sample_out exp %h got %h, saturated exp %b got %b",
							e.smp, sample_out, e.clip, saturated);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("mlsa_warped_cascade_filter test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = '0;
		sample_in = '0;
		coef_index = '0;
		coef_value = '0;
		out_ready = 1'b0;
		in_took = 1'b0;
		errors = 0;
		mismatches = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (dly_line[s, k]) dly_line[s][k] = 0;
		foreach (sec_out[i]) sec_out[i] = 0;
		foreach (cep_tab[i]) cep_tab[i] = 0;
		foreach (pade_tab[i]) pade_tab[i] = 0;
		cfg_alpha = longint'(ALPHA_RST);
		cfg_pade = 5;
		cfg_order = 24;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings.
		pending_reqs.push_back(make_req(OP_FILT, 32'sh7fffffff, 6'd0, 32'sd0));
		pending_reqs.push_back(make_req(OP_CEP, 32'sd0, 6'd2, 32'sh7fffffff));
		pending_reqs.push_back(make_req(OP_CEP, 32'sd0, 6'd40, 32'sh80000000));
		pending_reqs.push_back(make_req(OP_CEP, 32'sd0, 6'd41, 32'sh01000000));
		pending_reqs.push_back(make_req(OP_CEP, 32'sd0, 6'd63, 32'sh01000000));
		pending_reqs.push_back(make_req(OP_CEP, 32'sd0, 6'd0, 32'sh00800000));
		pending_reqs.push_back(make_req(OP_CEP, 32'sd0, 6'd3, 32'sh00400000));
		pending_reqs.push_back(make_req(OP_PADE, 32'sd0, 6'd0, 32'sh7fffffff));
		pending_reqs.push_back(make_req(OP_PADE, 32'sd0, 6'd1, 32'sh00800000));
		pending_reqs.push_back(make_req(OP_PADE, 32'sd0, 6'd5, 32'sh80000000));
		pending_reqs.push_back(make_req(OP_PADE, 32'sd0, 6'd6, 32'sh7fffffff));
		pending_reqs.push_back(make_req(OP_PADE, 32'sd0, 6'd2, 32'sh00200000));
		pending_reqs.push_back(make_req(OP_RSVD, 32'sh7fffffff, 6'd63, 32'sh7fffffff));
		pending_reqs.push_back(make_req(OP_FILT, 32'sh7fffffff, 6'd0, 32'sd0));
		pending_reqs.push_back(make_req(OP_FILT, 32'sh80000000, 6'd0, 32'sd0));
		pending_reqs.push_back(make_req(OP_FILT, 32'sd0, 6'd0, 32'sd0));
		pending_reqs.push_back(make_req(OP_FILT, -32'sd1, 6'd0, 32'sd0));
		pending_reqs.push_back(make_req(OP_FILT, 32'sh01000000, 6'd0, 32'sd0));
		pending_reqs.push_back(make_req(OP_FILT, 32'sh80000000, 6'd0, 32'sd0));

		// Most negative alpha code, then the positive limit.
		run_phase(25'h1000000, 3'd1, 6'd2, 200, 1);
		run_phase(25'h0ffffff, 3'd2, 6'd3, 200, 2);
		run_phase(25'($urandom), 3'd3, 6'd4, 200, 3);
		// Pade order zero and a first-order filter with no taps.
		run_phase(25'd0, 3'd0, 6'd1, 150, 0);
		run_phase(25'($urandom), 3'd2, 6'd0, 100, 1);
		// Orders above the limits are clamped; keep these phases short.
		run_phase(-25'sd7046431, 3'd7, 6'd63, 12, 2);
		run_phase(25'($urandom), 3'd5, 6'd40, 12, 3);
		run_phase(25'($urandom), 3'd4, 6'd5, 250, 0);
		run_phase(25'($urandom), 3'd3, 6'd6, 250, 2);
		run_phase(25'h1000000 | 25'($urandom), 3'd2, 6'd2, 200, 1);

		drain();
		if (errors == 0)
			$display("mlsa_warped_cascade_filter test passed");
		else
			$display("mlsa_warped_cascade_filter test failed");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/mwc_pkg.sv
src/mwc_mul.sv
src/mlsa_warped_cascade_filter.sv
verif/tb_mlsa_warped_cascade_filter.sv
